>>> hdl/jres_pkg.sv
// ----------------------------------------------------------------------------
// jres_pkg: shared types and constants
// Item kinds, register indexes, controller states, datapath opcodes and
// saturation of divider quotients.
// ----------------------------------------------------------------------------
package jres_pkg;

  localparam int NUM_W     = 52;
  localparam int DEN_W     = 32;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [32:0] PI_Q16     = 33'sd205887;
  localparam logic signed [32:0] TWO_PI_Q16 = 33'sd411775;
  localparam logic [19:0]        US_PER_S   = 20'd1000000;
  // x / 5 == (x * DECAY_RECIP) >> 34 for any 32-bit x
  localparam logic [31:0]        DECAY_RECIP = 32'hCCCC_CCCD;

  localparam logic [7:0]  MASK_RESET         = 8'd0;
  localparam logic [19:0] MIN_INTERVAL_RESET = 20'd25000;
  localparam logic [30:0] MAX_STEP_RESET     = 31'd26214;
  localparam logic [30:0] DEADBAND_RESET     = 31'd655;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_DECAY   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONT_MASK    = 2'd0,
    CFG_MIN_INTERVAL = 2'd1,
    CFG_MAX_STEP     = 2'd2,
    CFG_DEADBAND     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_DIFF,
    DP_WRAP,
    DP_MUL,
    DP_DIV_START,
    DP_VSAT,
    DP_VDIFF,
    DP_ACOMMIT,
    DP_DECAY,
    DP_DSAT,
    DP_PLAN,
    DP_SLEW,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIFF,
    ST_WRAP,
    ST_MULV,
    ST_STARTV,
    ST_DIVV,
    ST_VSAT,
    ST_VDIFF,
    ST_MULA,
    ST_STARTA,
    ST_DIVA,
    ST_ACOMMIT,
    ST_DECAY,
    ST_DSAT,
    ST_PLAN,
    ST_SLEW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic   in_ready;
    dp_op_t op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_range;
    logic       sample_ok;
    logic       decay_zero;
    logic       div_busy;
    logic       out_busy;
  } stat_t;

  // signed 32-bit value of a quotient magnitude, clamped
  function automatic logic signed [31:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      if (q > NUM_W'(32'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else r = signed'(q[31:0]);
    end else begin
      if (q > NUM_W'(33'h0_8000_0000)) r = 32'sh8000_0000;
      else r = signed'(~q[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

>>> hdl/jres_in_if.sv
// ----------------------------------------------------------------------------
// jres_in_if: input item channel
// Valid/ready channel carrying one joint item per beat.
// ----------------------------------------------------------------------------
interface jres_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         joint;
  logic signed [31:0] position;
  logic [31:0]        stamp_us;
  logic signed [31:0] planner_velocity;

  modport source (output valid, output kind, output joint, output position,
                  output stamp_us, output planner_velocity, input ready);
  modport sink (input valid, input kind, input joint, input position,
                input stamp_us, input planner_velocity, output ready);
endinterface

>>> hdl/jres_out_if.sv
// ----------------------------------------------------------------------------
// jres_out_if: result channel
// Valid/ready channel carrying one joint result per beat.
// ----------------------------------------------------------------------------
interface jres_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_joint;
  logic signed [31:0] measured_velocity;
  logic signed [31:0] measured_accel;
  logic signed [31:0] drive_command;
  logic               sample_taken;

  modport source (output valid, output out_joint, output measured_velocity,
                  output measured_accel, output drive_command, output sample_taken,
                  input ready);
  modport sink (input valid, input out_joint, input measured_velocity,
                input measured_accel, input drive_command, input sample_taken,
                output ready);
endinterface

>>> hdl/jres_div.sv
// ----------------------------------------------------------------------------
// jres_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, NUM_W quotient bits per pass.
// ----------------------------------------------------------------------------
module jres_div import jres_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quot    <= num;
      divisor <= den;
    end else if (busy) begin
      rem  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], qbit};
    end
  end

endmodule

>>> hdl/jres_dp.sv
// ----------------------------------------------------------------------------
// jres_dp: estimator datapath
// Per-joint state, config registers, difference/wrap, multiplier, shared
// divider, saturation, deadband decay, slew limit and the result register.
// ----------------------------------------------------------------------------
module jres_dp import jres_pkg::*; #(
  parameter int JOINTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  input  logic [1:0]           kind,
  input  logic [2:0]           joint,
  input  logic signed [31:0]   position,
  input  logic [31:0]          stamp_us,
  input  logic signed [31:0]   planner_velocity,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  jres_out_if.source           results
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  logic [7:0]  cont_mask;
  logic [19:0] min_interval;
  logic [30:0] max_step;
  logic [30:0] deadband;

  logic signed [31:0] last_position    [JOINTS];
  logic signed [31:0] last_velocity    [JOINTS];
  logic signed [31:0] last_accel       [JOINTS];
  logic [31:0]        sample_time      [JOINTS];
  logic signed [31:0] command_velocity [JOINTS];

  logic [1:0]         kind_r;
  logic [2:0]         joint_r;
  logic signed [31:0] pos_r;
  logic [31:0]        stamp_r;
  logic signed [31:0] plan_r;

  logic signed [32:0] opnd;
  logic [NUM_W-1:0]   prod;
  logic               neg;
  logic [DEN_W-1:0]   dvsr;
  logic signed [31:0] vel_new;
  logic signed [31:0] cmd_new;
  logic               taken;
  logic [63:0]        dec_prod;

  logic               rvalid;
  logic [2:0]         r_joint;
  logic signed [31:0] r_vel;
  logic signed [31:0] r_acc;
  logic signed [31:0] r_cmd;
  logic               r_taken;

  logic [JW-1:0]      jidx;
  logic               in_range;
  logic signed [31:0] cur_vel;
  logic signed [31:0] cur_cmd;
  logic [31:0]        dt_now;
  logic [19:0]        min_eff;
  logic               wrap_hit;
  logic signed [32:0] opnd_mag;
  logic [NUM_W-1:0]   mul_full;
  logic signed [32:0] cmd_ext;
  logic signed [32:0] cmd_mag;
  logic [31:0]        dec_num;
  logic [63:0]        dec_full;
  logic [31:0]        dec_res;
  logic signed [32:0] vel_new_x;
  logic signed [32:0] cur_vel_x;
  logic signed [32:0] pos_x;
  logic signed [32:0] last_pos_x;
  logic signed [33:0] sl_cmd, sl_vel, sl_lim, sl_diff, sl_hi, sl_lo;
  logic signed [31:0] slew_val;
  logic               div_busy;
  logic [NUM_W-1:0]   quot;

  assign jidx     = JW'(joint_r);
  assign in_range = {29'd0, joint_r} < 32'(JOINTS);
  assign cur_vel  = last_velocity[jidx];
  assign cur_cmd  = command_velocity[jidx];

  assign min_eff   = (min_interval == 20'd0) ? 20'd1 : min_interval;
  assign dt_now    = stamp_r - sample_time[jidx];
  assign wrap_hit  = cont_mask[joint_r] && (opnd > PI_Q16 || opnd < -PI_Q16);
  assign opnd_mag  = opnd[32] ? -opnd : opnd;
  assign mul_full  = NUM_W'(opnd_mag[31:0]) * NUM_W'(US_PER_S);
  assign cmd_ext   = 33'(cur_cmd);
  assign cmd_mag   = cmd_ext[32] ? -cmd_ext : cmd_ext;
  assign vel_new_x = 33'(vel_new);
  assign cur_vel_x = 33'(cur_vel);
  assign pos_x     = 33'(pos_r);
  assign last_pos_x = 33'(last_position[jidx]);

  // 4|c|/5 truncated = |c| - ceil(|c|/5) = |c| - floor((|c|+4)/5)
  assign dec_num  = cmd_mag[31:0] + 32'd4;
  assign dec_full = 64'(dec_num) * 64'(DECAY_RECIP);
  assign dec_res  = cmd_mag[31:0] - {2'b00, dec_prod[63:34]};

  assign sl_cmd  = 34'(cmd_new);
  assign sl_vel  = 34'(cur_vel);
  assign sl_lim  = {3'b000, max_step};
  assign sl_diff = sl_cmd - sl_vel;
  assign sl_hi   = sl_vel + sl_lim;
  assign sl_lo   = sl_vel - sl_lim;

  always_comb begin
    slew_val = cmd_new;
    if (cmd_new != 32'sd0) begin
      if (sl_diff > sl_lim) slew_val = (sl_hi > SAT_MAX) ? SAT_MAX[31:0] : sl_hi[31:0];
      else if (sl_diff < -sl_lim) slew_val = (sl_lo < SAT_MIN) ? SAT_MIN[31:0] : sl_lo[31:0];
    end
  end

  jres_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.op == DP_DIV_START),
    .num   (prod),
    .den   (dvsr),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_mask    <= MASK_RESET;
      min_interval <= MIN_INTERVAL_RESET;
      max_step     <= MAX_STEP_RESET;
      deadband     <= DEADBAND_RESET;
    end else if (write_enable) begin
      case (cfg_reg_t'(write_index))
        CFG_CONT_MASK:    cont_mask    <= write_data[7:0];
        CFG_MIN_INTERVAL: min_interval <= write_data[19:0];
        CFG_MAX_STEP:     max_step     <= write_data;
        CFG_DEADBAND:     deadband     <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        last_position[i]    <= '0;
        last_velocity[i]    <= '0;
        last_accel[i]       <= '0;
        sample_time[i]      <= '0;
        command_velocity[i] <= '0;
      end
    end else begin
      case (ctrl.op)
        DP_ACOMMIT: begin
          last_accel[jidx]    <= sat_quot(quot, neg);
          last_velocity[jidx] <= vel_new;
          last_position[jidx] <= pos_r;
          sample_time[jidx]   <= stamp_r;
        end
        DP_SLEW: command_velocity[jidx] <= slew_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_LOAD: begin
        kind_r  <= kind;
        joint_r <= joint;
        pos_r   <= position;
        stamp_r <= stamp_us;
        plan_r  <= planner_velocity;
      end
      DP_DIFF: begin
        opnd <= pos_x - last_pos_x;
        dvsr <= dt_now;
      end
      DP_WRAP: begin
        if (wrap_hit) opnd <= opnd[32] ? opnd + TWO_PI_Q16 : opnd - TWO_PI_Q16;
      end
      DP_MUL: begin
        prod <= mul_full;
        neg  <= opnd[32];
      end
      DP_VSAT:  vel_new <= sat_quot(quot, neg);
      DP_VDIFF: opnd <= vel_new_x - cur_vel_x;
      DP_DECAY: begin
        if (stat.decay_zero) cmd_new <= '0;
        else dec_prod <= dec_full;
      end
      DP_DSAT: cmd_new <= cmd_ext[32] ? -signed'(dec_res) : signed'(dec_res);
      DP_PLAN: cmd_new <= plan_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken  <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      if (ctrl.op == DP_LOAD) taken <= 1'b0;
      else if (ctrl.op == DP_ACOMMIT) taken <= 1'b1;
      if (ctrl.op == DP_EMIT) rvalid <= 1'b1;
      else if (results.ready) rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == DP_EMIT) begin
      r_joint <= joint_r;
      if (in_range) begin
        r_vel   <= cur_vel;
        r_acc   <= last_accel[jidx];
        r_cmd   <= cur_cmd;
        r_taken <= taken;
      end else begin
        r_vel   <= '0;
        r_acc   <= '0;
        r_cmd   <= '0;
        r_taken <= 1'b0;
      end
    end
  end

  assign results.valid             = rvalid;
  assign results.out_joint         = r_joint;
  assign results.measured_velocity = r_vel;
  assign results.measured_accel    = r_acc;
  assign results.drive_command     = r_cmd;
  assign results.sample_taken      = r_taken;

  assign stat.kind       = kind_r;
  assign stat.in_range   = in_range;
  assign stat.sample_ok  = dt_now >= {12'd0, min_eff};
  assign stat.decay_zero = cmd_mag < {2'b00, deadband};
  assign stat.div_busy   = div_busy;
  assign stat.out_busy   = rvalid && !results.ready;

endmodule

>>> hdl/jres_ctrl.sv
// ----------------------------------------------------------------------------
// jres_ctrl: item sequencer
// Steps the datapath through sample, command and decay sequences and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module jres_ctrl import jres_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!stat.in_range) begin
          state_next = ST_FINISH;
        end else begin
          case (stat.kind)
            KIND_SAMPLE:  state_next = stat.sample_ok ? ST_DIFF : ST_FINISH;
            KIND_COMMAND: state_next = ST_PLAN;
            KIND_DECAY:   state_next = ST_DECAY;
            default:      state_next = ST_FINISH;
          endcase
        end
      end
      ST_DIFF:    state_next = ST_WRAP;
      ST_WRAP:    state_next = ST_MULV;
      ST_MULV:    state_next = ST_STARTV;
      ST_STARTV:  state_next = ST_DIVV;
      ST_DIVV:    if (!stat.div_busy) state_next = ST_VSAT;
      ST_VSAT:    state_next = ST_VDIFF;
      ST_VDIFF:   state_next = ST_MULA;
      ST_MULA:    state_next = ST_STARTA;
      ST_STARTA:  state_next = ST_DIVA;
      ST_DIVA:    if (!stat.div_busy) state_next = ST_ACOMMIT;
      ST_ACOMMIT: state_next = ST_FINISH;
      ST_DECAY:   state_next = stat.decay_zero ? ST_SLEW : ST_DSAT;
      ST_DSAT:    state_next = ST_SLEW;
      ST_PLAN:    state_next = ST_SLEW;
      ST_SLEW:    state_next = ST_FINISH;
      ST_FINISH:  if (!stat.out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready = (state == ST_IDLE);
    ctrl.op       = DP_NONE;
    case (state)
      ST_IDLE:    ctrl.op = in_valid ? DP_LOAD : DP_NONE;
      ST_DIFF:    ctrl.op = DP_DIFF;
      ST_WRAP:    ctrl.op = DP_WRAP;
      ST_MULV:    ctrl.op = DP_MUL;
      ST_MULA:    ctrl.op = DP_MUL;
      ST_STARTV:  ctrl.op = DP_DIV_START;
      ST_STARTA:  ctrl.op = DP_DIV_START;
      ST_VSAT:    ctrl.op = DP_VSAT;
      ST_VDIFF:   ctrl.op = DP_VDIFF;
      ST_ACOMMIT: ctrl.op = DP_ACOMMIT;
      ST_DECAY:   ctrl.op = DP_DECAY;
      ST_DSAT:    ctrl.op = DP_DSAT;
      ST_PLAN:    ctrl.op = DP_PLAN;
      ST_SLEW:    ctrl.op = DP_SLEW;
      ST_FINISH:  ctrl.op = stat.out_busy ? DP_NONE : DP_EMIT;
      default:    ctrl.op = DP_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == DP_DIV_START |-> !stat.div_busy)
    else $error("divider started while busy");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == DP_DIV_START |=> stat.div_busy)
    else $error("divider did not start");

  a_commit_sample: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACOMMIT |-> stat.in_range && stat.kind == KIND_SAMPLE && !stat.div_busy)
    else $error("sample commit outside a valid sample");

  a_slew_cmd: assert property (@(posedge clk) disable iff (rst)
    state == ST_SLEW |-> stat.in_range && (stat.kind == KIND_COMMAND || stat.kind == KIND_DECAY))
    else $error("slew limit on a non-command item");
`endif

endmodule

>>> hdl/joint_rate_estimator_command_shaper_top.sv
// ----------------------------------------------------------------------------
// joint_rate_estimator_command_shaper_top: joint rate estimator and shaper
// Finite-difference velocity/acceleration per joint with continuous-joint
// wrap, plus deadband decay and slew limiting of the drive command.
// ----------------------------------------------------------------------------
// Throughput: one item in flight; the input is ready again as the result register
//   loads, and a sample runs twice on the shared 52-step divider (velocity, then
//   acceleration). A held result stalls the input.
// Reset: synchronous rst clears joint state and loads register defaults.
module joint_rate_estimator_command_shaper_top import jres_pkg::*; #(
  parameter int JOINTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  jres_in_if.sink              items,
  jres_out_if.source           results
);

  ctrl_t ctrl;
  stat_t stat;

  assign items.ready = ctrl.in_ready;

  jres_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  jres_dp #(
    .JOINTS (JOINTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .write_enable     (write_enable),
    .write_index      (write_index),
    .write_data       (write_data),
    .kind             (items.kind),
    .joint            (items.joint),
    .position         (items.position),
    .stamp_us         (items.stamp_us),
    .planner_velocity (items.planner_velocity),
    .ctrl             (ctrl),
    .stat             (stat),
    .results          (results)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: joint rate estimator and command shaper testbench
// Drives sample, command, decay and unused-kind beats through the valid/ready channels.
// An in-bench model of the per-joint velocity, acceleration and command
// state predicts each result, and the monitor checks every field of every
// beat in order. Traffic runs with random gaps and stalls, one long output
// stall and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import jres_pkg::*;

  localparam int JOINTS = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 150;
  localparam int CHOKE_CYCLES = 400;
  localparam int PHASE_ITEMS = 112;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint PI_FX = 205887;
  localparam longint TWO_PI_FX = 411775;
  localparam longint US_PER_SEC = 1000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         joint;
    logic signed [31:0] position;
    logic [31:0]        stamp_us;
    logic signed [31:0] planner_velocity;
  } joint_item_t;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] velocity;
    logic signed [31:0] accel;
    logic signed [31:0] command;
    logic               taken;
  } joint_report_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           write_enable = 1'b0;
  cfg_reg_t       write_index = CFG_CONT_MASK;
  logic [CFG_W-1:0] write_data = '0;

  logic        send_valid = 1'b0;
  joint_item_t on_wire = '0;
  logic        take_ready = 1'b0;

  jres_in_if  items();
  jres_out_if results();

  assign items.valid            = send_valid;
  assign items.kind             = on_wire.kind;
  assign items.joint            = on_wire.joint;
  assign items.position         = on_wire.position;
  assign items.stamp_us         = on_wire.stamp_us;
  assign items.planner_velocity = on_wire.planner_velocity;
  assign results.ready          = take_ready;

  joint_rate_estimator_command_shaper_top #(.JOINTS(JOINTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .items        (items),
    .results      (results)
  );

  // model copy of registers and per-joint state
  logic [7:0]  wrap_mask  = 8'd0;
  logic [19:0] min_gap_us = 20'd25000;
  logic [30:0] slew_step  = 31'd26214;
  logic [30:0] dead_zone  = 31'd655;

  logic signed [31:0] pos_mem   [JOINTS] = '{default: '0};
  logic signed [31:0] vel_mem   [JOINTS] = '{default: '0};
  logic signed [31:0] acc_mem   [JOINTS] = '{default: '0};
  logic [31:0]        stamp_mem [JOINTS] = '{default: '0};
  logic signed [31:0] cmd_mem   [JOINTS] = '{default: '0};

  // generator-side trajectory per joint
  logic [31:0] gen_stamp [JOINTS] = '{default: '0};
  longint      gen_pos   [JOINTS] = '{default: 0};

  joint_item_t   joint_items[$];
  joint_report_t pending_reports[$];

  int mismatches = 0;
  int send_idle_max = 0;
  int recv_idle_max = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit choke_armed = 1'b0;
  bit choke_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic void slew_clamp(input int unsigned j);
    longint cmd, vel, lim;
    cmd = longint'(cmd_mem[j]);
    vel = longint'(vel_mem[j]);
    lim = longint'(slew_step);
    if (cmd == 0) return;
    if (cmd - vel > lim) cmd_mem[j] = clamp32(vel + lim);
    else if (cmd - vel < -lim) cmd_mem[j] = clamp32(vel - lim);
  endfunction

  function automatic joint_report_t shape_and_estimate(input joint_item_t it);
    joint_report_t r;
    int unsigned j;
    logic [31:0] dt;
    logic [31:0] floor_us;
    longint span, delta, c, mag, dz;
    logic signed [31:0] v;
    j = 32'(it.joint);
    r = '0;
    r.joint = it.joint;
    case (it.kind)
      KIND_SAMPLE: begin
        dt = it.stamp_us - stamp_mem[j];
        floor_us = (min_gap_us == 0) ? 32'd1 : 32'(min_gap_us);
        if (dt >= floor_us) begin
          span = {32'd0, dt};
          delta = longint'($signed(it.position)) - longint'(pos_mem[j]);
          // continuous joint: take the short way round, once
          if (wrap_mask[j] && (delta > PI_FX || delta < -PI_FX))
            delta = (delta > 0) ? delta - TWO_PI_FX : delta + TWO_PI_FX;
          v = clamp32(delta * US_PER_SEC / span);
          acc_mem[j] = clamp32((longint'(v) - longint'(vel_mem[j])) * US_PER_SEC / span);
          vel_mem[j] = v;
          pos_mem[j] = it.position;
          stamp_mem[j] = it.stamp_us;
          r.taken = 1'b1;
        end
      end
      KIND_COMMAND: begin
        cmd_mem[j] = it.planner_velocity;
        slew_clamp(j);
      end
      KIND_DECAY: begin
        c = longint'(cmd_mem[j]);
        mag = (c < 0) ? -c : c;
        dz = longint'(dead_zone);
        if (mag < dz) cmd_mem[j] = '0;
        else cmd_mem[j] = 32'(c * 4 / 5);
        slew_clamp(j);
      end
      default: ;
    endcase
    r.velocity = vel_mem[j];
    r.accel = acc_mem[j];
    r.command = cmd_mem[j];
    return r;
  endfunction

  function automatic joint_item_t random_item();
    joint_item_t it;
    int unsigned roll, j, floor_us, reach;
    longint p;
    it = '0;
    roll = $urandom_range(0, 99);
    j = $urandom_range(0, JOINTS - 1);
    it.joint = 3'(j);
    floor_us = (min_gap_us == 0) ? 32'd1 : 32'(min_gap_us);
    if (roll < 10) begin
      it.kind = 2'($urandom_range(0, 3));
      it.position = $urandom;
      it.stamp_us = $urandom;
      it.planner_velocity = $urandom;
      if (it.kind == KIND_SAMPLE) begin
        gen_stamp[j] = it.stamp_us;
        gen_pos[j] = longint'($signed(it.position));
      end
    end else if (roll < 62) begin
      it.kind = KIND_SAMPLE;
      if ($urandom_range(0, 4) == 0) gen_stamp[j] += $urandom_range(0, floor_us - 1);
      else gen_stamp[j] += $urandom_range(floor_us, 3 * floor_us);
      reach = ($urandom_range(0, 5) == 0) ? 32'h6_0000 : 32'h8000;
      p = gen_pos[j] + longint'($urandom_range(0, 2 * reach)) - reach;
      if (wrap_mask[j]) begin
        if (p > PI_FX) p -= TWO_PI_FX;
        else if (p < -PI_FX) p += TWO_PI_FX;
      end
      gen_pos[j] = clamp32(p);
      it.position = 32'(gen_pos[j]);
      it.stamp_us = gen_stamp[j];
    end else if (roll < 82) begin
      it.kind = KIND_COMMAND;
      it.planner_velocity = 32'(longint'($urandom_range(0, 32'hC_0000)) - 32'h6_0000);
    end else begin
      it.kind = KIND_DECAY;
    end
    return it;
  endfunction

  task automatic push_item(input logic [1:0] kind, input logic [2:0] joint,
                           input logic signed [31:0] position, input logic [31:0] stamp,
                           input logic signed [31:0] plan);
    joint_item_t it;
    it.kind = kind;
    it.joint = joint;
    it.position = position;
    it.stamp_us = stamp;
    it.planner_velocity = plan;
    joint_items = {joint_items, it};
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [30:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      CFG_CONT_MASK:    wrap_mask = value[7:0];
      CFG_MIN_INTERVAL: min_gap_us = value[19:0];
      CFG_MAX_STEP:     slew_step = value;
      CFG_DEADBAND:     dead_zone = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (joint_items.size() != 0 || send_valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] mask, input logic [19:0] min_us,
                           input logic [30:0] step_lim, input logic [30:0] band,
                           input int send_idle, input int recv_idle, input bit choke);
    write_reg(CFG_CONT_MASK, 31'(mask));
    write_reg(CFG_MIN_INTERVAL, 31'(min_us));
    write_reg(CFG_MAX_STEP, step_lim);
    write_reg(CFG_DEADBAND, band);
    send_idle_max = send_idle;
    recv_idle_max = recv_idle;
    repeat (PHASE_ITEMS) joint_items = {joint_items, random_item()};
    if (choke) choke_armed = 1'b1;
    wait_idle();
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    bit live;
    live = send_valid;
    if (rst) begin
      send_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (send_valid && items.ready) begin
        pending_reports = {pending_reports, shape_and_estimate(on_wire)};
        live = 1'b0;
        send_wait = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
      end
      if (!live) begin
        if (send_wait > 0) begin
          send_wait--;
          send_valid <= 1'b0;
        end else if (joint_items.size() != 0) begin
          on_wire <= joint_items.pop_front();
          send_valid <= 1'b1;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    joint_report_t want;
    if (rst) begin
      take_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (take_ready && results.valid) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got joint %0d", $time,
                   results.out_joint);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("out_joint", 32'(want.joint), 32'(results.out_joint));
          check_field("measured_velocity", want.velocity, results.measured_velocity);
          check_field("measured_accel", want.accel, results.measured_accel);
          check_field("drive_command", want.command, results.drive_command);
          check_field("sample_taken", 32'(want.taken), 32'(results.sample_taken));
        end
        recv_wait = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
      end
      if (choke_armed && !choke_done) begin
        recv_wait = CHOKE_CYCLES;
        choke_done = 1'b1;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // register defaults: saturating commands, deadband, rejects, stamp wrap
    send_idle_max = 4;
    recv_idle_max = 4;
    push_item(KIND_COMMAND, 3'd0, 32'sd0, 32'd0, 32'sh7FFF_FFFF);
    push_item(KIND_COMMAND, 3'd1, 32'sd0, 32'd0, 32'sh8000_0000);
    push_item(KIND_COMMAND, 3'd2, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_DECAY, 3'd0, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_COMMAND, 3'd3, 32'sd0, 32'd0, 32'sd300);
    push_item(KIND_DECAY, 3'd3, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_DECAY, 3'd1, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_UNUSED, 3'd4, 32'(signed'($urandom)), $urandom, 32'(signed'($urandom)));
    push_item(KIND_SAMPLE, 3'd4, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_SAMPLE, 3'd5, 32'sh7FFF_FFFF, 32'd100, 32'sd0);
    push_item(KIND_SAMPLE, 3'd5, 32'sh7FFF_FFFF, 32'd25000, 32'sd0);
    push_item(KIND_SAMPLE, 3'd5, 32'sh8000_0000, 32'd50000, 32'sd0);
    push_item(KIND_SAMPLE, 3'd5, 32'sd0, 32'd10, 32'sd0);
    push_item(KIND_SAMPLE, 3'd6, 32'sd12345, 32'hFFFF_FFFF, 32'sd0);
    push_item(KIND_COMMAND, 3'd5, 32'sd0, 32'd0, 32'sd0);
    push_item(KIND_COMMAND, 3'd5, 32'sd0, 32'd0, 32'sh4000_0000);
    wait_idle();

    // all joints continuous, zero interval, widest slew, no deadband
    write_reg(CFG_CONT_MASK, 31'hFF);
    write_reg(CFG_MIN_INTERVAL, 31'd0);
    write_reg(CFG_MAX_STEP, 31'h7FFF_FFFF);
    write_reg(CFG_DEADBAND, 31'd0);
    push_item(KIND_SAMPLE, 3'd7, 32'sd205888, 32'd1, 32'sd0);
    push_item(KIND_SAMPLE, 3'd7, -32'sd205888, 32'd2, 32'sd0);
    push_item(KIND_SAMPLE, 3'd7, -32'sd1, 32'd3, 32'sd0);
    push_item(KIND_SAMPLE, 3'd7, 32'sh7FFF_FFFF, 32'd4, 32'sd0);
    push_item(KIND_SAMPLE, 3'd7, 32'sh8000_0000, 32'd4, 32'sd0);
    push_item(KIND_COMMAND, 3'd7, 32'sd0, 32'd0, 32'sh8000_0000);
    push_item(KIND_DECAY, 3'd6, 32'sd0, 32'd0, 32'sd0);
    wait_idle();

    run_phase(8'($urandom), 20'($urandom_range(1000, 50000)),
              31'($urandom_range(0, 32'h8_0000)), 31'($urandom_range(0, 32'h2_0000)),
              4, 4, 1'b0);
    run_phase(8'h00, 20'd1000000, 31'd0, 31'h7FFF_FFFF, 0, 0, 1'b0);
    run_phase(8'hFF, 20'd1, 31'h7FFF_FFFF, 31'd0, 0, 4, 1'b1);
    run_phase(8'($urandom), 20'($urandom_range(1, 1000000)), 31'($urandom), 31'($urandom),
              4, 0, 1'b0);

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> joint_rate_estimator_command_shaper_top.f
hdl/jres_pkg.sv
hdl/jres_in_if.sv
hdl/jres_out_if.sv
hdl/jres_div.sv
hdl/jres_dp.sv
hdl/jres_ctrl.sv
hdl/joint_rate_estimator_command_shaper_top.sv
sim/tb.sv
